### hdl/bdtg_pkg.sv
// Shared types, constants and width helpers for the border distance texel generator.
// No dependencies; imported by every module of the block.
package bdtg_pkg;

  localparam int TILE_SIZE_DEFAULT = 8;
  localparam int COORD_W = 3;
  localparam int VALUE_W = 8;
  localparam int ADDR_W = 14;
  localparam int VALUE_MAX = 255;
  localparam int SCALE = 65025;
  localparam int ATLAS_TILES = 16;

  typedef struct packed {
    logic [7:0]         tile_mask;
    logic [COORD_W-1:0] texel_col;
    logic [COORD_W-1:0] texel_row;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] texel_value;
    logic [ADDR_W-1:0]  atlas_address;
  } result_t;

  // bits of a distance in half-texel units, 0 .. 2s-1
  function automatic int dist_w(input int tile_size);
    return $clog2(2 * tile_size);
  endfunction

  // bits of the square root of the scaled squared corner distance
  function automatic int root_w(input int tile_size);
    return $clog2(2 * tile_size) + 9;
  endfunction

endpackage

### hdl/border_distance_texel_generator_unit.sv
// Top level of the border distance texel generator.
// Instantiates bdtg_front, bdtg_sqrt and bdtg_div; uses bdtg_pkg.
//
// Usage:
//   item channel (item_valid/item_ready/item) takes a tile mask and a texel column
//   and row; result channel (result_valid/result_ready/result) returns the distance
//   byte and the texel's address in the 16 x 16 tile atlas, one result per item,
//   in order.
//   The pipeline is two front stages, one stage per root bit of the square root
//   pipeline (root_w = clog2(2*TILE_SIZE) + 9) and three divide and minimum
//   stages.
//   Throughput is one transaction per cycle while the receiver does not stall; every
//   stage is a register with its own valid bit.
//   Reset (rst, synchronous) empties the pipeline; item_ready is high in the
//   following cycle.
//   When the receiver stalls, the result register holds its transaction and
//   item_ready stays high while any stage of the pipeline is empty, so bubbles
//   are squeezed out before the input is held off. Nothing is dropped or repeated.
module border_distance_texel_generator_unit #(
  parameter int TILE_SIZE = bdtg_pkg::TILE_SIZE_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  bdtg_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output bdtg_pkg::result_t result
);
  import bdtg_pkg::*;

  localparam int RW = root_w(TILE_SIZE);

  typedef struct packed {
    logic [RW-1:0]     edge_num;
    logic [ADDR_W-1:0] addr;
  } side_t;

  logic              f_valid;
  logic              f_ready;
  logic [2*RW-1:0]   f_scaled;
  logic [RW-1:0]     f_edge_num;
  logic [ADDR_W-1:0] f_addr;
  side_t             f_side;

  logic              s_valid;
  logic              s_ready;
  logic [RW-1:0]     s_root;
  side_t             s_side;

  bdtg_front #(
    .TILE_SIZE(TILE_SIZE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .in_ready (item_ready),
    .item     (item),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .scaled   (f_scaled),
    .edge_num (f_edge_num),
    .addr     (f_addr)
  );

  assign f_side.edge_num = f_edge_num;
  assign f_side.addr = f_addr;

  bdtg_sqrt #(
    .TILE_SIZE(TILE_SIZE),
    .side_t   (side_t)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .radicand (f_scaled),
    .side_in  (f_side),
    .out_valid(s_valid),
    .out_ready(s_ready),
    .root     (s_root),
    .side_out (s_side)
  );

  bdtg_div #(
    .TILE_SIZE(TILE_SIZE)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_valid),
    .in_ready (s_ready),
    .root     (s_root),
    .edge_num (s_side.edge_num),
    .addr     (s_side.addr),
    .out_valid(result_valid),
    .out_ready(result_ready),
    .result   (result)
  );

endmodule

### hdl/bdtg_front.sv
// Front end: coordinate clamp, corner squared distances, edge distance and atlas address.
// Two register stages; uses bdtg_pkg.
module bdtg_front #(
  parameter int TILE_SIZE = bdtg_pkg::TILE_SIZE_DEFAULT,
  localparam int RW = bdtg_pkg::root_w(TILE_SIZE)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bdtg_pkg::item_t             item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2*RW-1:0]             scaled,
  output logic [RW-1:0]               edge_num,
  output logic [bdtg_pkg::ADDR_W-1:0] addr
);
  import bdtg_pkg::*;

  localparam int DW = dist_w(TILE_SIZE);
  localparam int SQW = 2 * DW + 1;
  localparam int NW = 2 * RW;
  localparam logic [DW:0] SPAN = (DW + 1)'(2 * TILE_SIZE);
  localparam logic [COORD_W-1:0] CLAMP = COORD_W'(TILE_SIZE - 1);
  localparam logic [RW-1:0] EDGE_NONE = RW'(VALUE_MAX * 2 * TILE_SIZE);
  localparam logic [NW-1:0] CORNER_NONE = {1'b0, {(NW - 1){1'b1}}};

  // stage 1
  logic                 v1;
  logic [SQW-1:0]       sq1 [4];
  logic [3:0]           cmask1;
  logic [DW-1:0]        emin1;
  logic                 eany1;
  logic [ADDR_W-1:0]    ahi1;
  logic [ADDR_W-1:0]    alo1;
  logic                 rdy1;
  logic                 rdy2;

  logic [COORD_W-1:0]   col;
  logic [COORD_W-1:0]   row;
  logic [DW-1:0]        px;
  logic [DW-1:0]        py;
  logic [DW-1:0]        qx;
  logic [DW-1:0]        qy;
  logic [SQW-1:0]       sq_next [4];
  logic [DW-1:0]        emin_next;

  always_comb begin
    logic [DW-1:0] edist [4];
    col = (int'(item.texel_col) >= TILE_SIZE) ? CLAMP : item.texel_col;
    row = (int'(item.texel_row) >= TILE_SIZE) ? CLAMP : item.texel_row;
    px = DW'({col, 1'b1});
    py = DW'({row, 1'b1});
    qx = DW'(SPAN - {1'b0, px});
    qy = DW'(SPAN - {1'b0, py});
    sq_next[0] = SQW'(px) * SQW'(px) + SQW'(py) * SQW'(py);
    sq_next[1] = SQW'(qx) * SQW'(qx) + SQW'(py) * SQW'(py);
    sq_next[2] = SQW'(qx) * SQW'(qx) + SQW'(qy) * SQW'(qy);
    sq_next[3] = SQW'(px) * SQW'(px) + SQW'(qy) * SQW'(qy);
    edist[0] = py;
    edist[1] = qx;
    edist[2] = qy;
    edist[3] = px;
    emin_next = '1;
    for (int i = 0; i < 4; i++) begin
      if (item.tile_mask[4 + i] && edist[i] < emin_next) begin
        emin_next = edist[i];
      end
    end
  end

  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sq1 <= sq_next;
      cmask1 <= item.tile_mask[3:0];
      emin1 <= emin_next;
      eany1 <= |item.tile_mask[7:4];
      ahi1 <= ADDR_W'(item.tile_mask[7:4]) * ADDR_W'(TILE_SIZE) + ADDR_W'(row);
      alo1 <= ADDR_W'(item.tile_mask[3:0]) * ADDR_W'(TILE_SIZE) + ADDR_W'(col);
    end
  end

  // stage 2
  logic [SQW-1:0] cmin;

  always_comb begin
    cmin = '1;
    for (int i = 0; i < 4; i++) begin
      if (cmask1[i] && sq1[i] < cmin) begin
        cmin = sq1[i];
      end
    end
  end

  assign rdy2 = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      scaled <= (|cmask1) ? NW'(cmin) * NW'(SCALE) : CORNER_NONE;
      edge_num <= eany1 ? RW'(emin1) * RW'(VALUE_MAX) : EDGE_NONE;
      addr <= ahi1 * ADDR_W'(ATLAS_TILES * TILE_SIZE) + alo1;
    end
  end

endmodule

### hdl/bdtg_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a side payload alongside; uses bdtg_pkg.
module bdtg_sqrt #(
  parameter int TILE_SIZE = bdtg_pkg::TILE_SIZE_DEFAULT,
  parameter type side_t = logic,
  localparam int RW = bdtg_pkg::root_w(TILE_SIZE)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2*RW-1:0] radicand,
  input  side_t           side_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [RW-1:0]   root,
  output side_t           side_out
);
  import bdtg_pkg::*;

  localparam int NW = 2 * RW;
  localparam int AW = NW + 1;

  logic          v   [RW];
  logic          rdy [RW];
  logic [AW-1:0] rem [RW];
  logic [AW-1:0] acc [RW];
  side_t         sd  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam logic [AW-1:0] BIT = AW'(1) << (NW - 2 - 2 * k);

    logic          v_in;
    logic          rdy_dn;
    logic [AW-1:0] rem_in;
    logic [AW-1:0] acc_in;
    side_t         sd_in;
    logic [AW-1:0] trial;
    logic [AW-1:0] rem_next;
    logic [AW-1:0] acc_next;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign rem_in = AW'(radicand);
      assign acc_in = '0;
      assign sd_in = side_in;
    end else begin : g_rest
      assign v_in = v[k-1];
      assign rem_in = rem[k-1];
      assign acc_in = acc[k-1];
      assign sd_in = sd[k-1];
    end

    if (k == RW - 1) begin : g_last
      assign rdy_dn = out_ready;
    end else begin : g_mid
      assign rdy_dn = rdy[k+1];
    end

    assign trial = acc_in + BIT;

    always_comb begin
      if (rem_in >= trial) begin
        rem_next = rem_in - trial;
        acc_next = (acc_in >> 1) + BIT;
      end else begin
        rem_next = rem_in;
        acc_next = acc_in >> 1;
      end
    end

    assign rdy[k] = !v[k] || rdy_dn;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem[k] <= rem_next;
        acc[k] <= acc_next;
        sd[k] <= sd_in;
      end
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = v[RW-1];
  assign root = RW'(acc[RW-1]);
  assign side_out = sd[RW-1];

endmodule

### hdl/bdtg_div.sv
// Divide corner root and edge numerator by the tile span (reciprocal multiply plus
// one correction step), then take the minimum and saturate. Uses bdtg_pkg.
module bdtg_div #(
  parameter int TILE_SIZE = bdtg_pkg::TILE_SIZE_DEFAULT,
  localparam int RW = bdtg_pkg::root_w(TILE_SIZE)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [RW-1:0]               root,
  input  logic [RW-1:0]               edge_num,
  input  logic [bdtg_pkg::ADDR_W-1:0] addr,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bdtg_pkg::result_t           result
);
  import bdtg_pkg::*;

  localparam int K = RW;
  localparam int PW = 2 * RW;
  localparam logic [RW-1:0] RECIP = RW'((2 ** K) / (2 * TILE_SIZE));
  localparam logic [RW-1:0] SPAN = RW'(2 * TILE_SIZE);
  localparam logic [RW-1:0] CAP = RW'(VALUE_MAX);

  logic              v1;
  logic              v2;
  logic              rdy1;
  logic              rdy2;
  logic              rdy3;

  // stage 1: reciprocal products
  logic [PW-1:0]     pc1;
  logic [PW-1:0]     pe1;
  logic [RW-1:0]     nc1;
  logic [RW-1:0]     ne1;
  logic [ADDR_W-1:0] addr1;

  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      pc1 <= PW'(root) * PW'(RECIP);
      pe1 <= PW'(edge_num) * PW'(RECIP);
      nc1 <= root;
      ne1 <= edge_num;
      addr1 <= addr;
    end
  end

  // stage 2: quotient estimate is exact or one low
  logic [RW-1:0]     qc0;
  logic [RW-1:0]     qe0;
  logic [RW-1:0]     rc;
  logic [RW-1:0]     re;
  logic [RW-1:0]     qc2;
  logic [RW-1:0]     qe2;
  logic [ADDR_W-1:0] addr2;

  assign qc0 = RW'(pc1 >> K);
  assign qe0 = RW'(pe1 >> K);
  assign rc = nc1 - qc0 * SPAN;
  assign re = ne1 - qe0 * SPAN;

  assign rdy2 = !v2 || rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      qc2 <= qc0 + RW'(rc >= SPAN);
      qe2 <= qe0 + RW'(re >= SPAN);
      addr2 <= addr1;
    end
  end

  // stage 3: minimum and saturation
  logic [RW-1:0] best;

  always_comb begin
    best = CAP;
    if (qc2 < best) begin
      best = qc2;
    end
    if (qe2 < best) begin
      best = qe2;
    end
  end

  assign rdy3 = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      result.texel_value <= VALUE_W'(best);
      result.atlas_address <= addr2;
    end
  end

endmodule

### hdl/bdtg_checker.sv
// Port-level checks for border_distance_texel_generator_unit and the bind that attaches them.
// Uses bdtg_pkg.
module bdtg_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input bdtg_pkg::result_t result
);
  import bdtg_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result transaction changed or dropped");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input held off with empty output stage");

  a_drain_accepts: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> item_ready)
    else $error("input held off while output drains");

endmodule

bind border_distance_texel_generator_unit bdtg_checker u_bdtg_checker (
  .clk         (clk),
  .rst         (rst),
  .item_ready  (item_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result      (result)
);
